// ===== rtl/core/suffix_array_builder_defines.svh =====
// ----------------------------------------------------------------------------
// Suffix array builder assertion macros
// Shared property wrappers for the concurrent checks at the top level.
// ----------------------------------------------------------------------------
`ifndef SUFFIX_ARRAY_BUILDER_DEFINES_SVH
`define SUFFIX_ARRAY_BUILDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("suffix_array_builder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SAB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("suffix_array_builder: next-cycle check failed");

`endif

// ===== rtl/core/sab_pkg.sv =====
// ----------------------------------------------------------------------------
// Suffix array builder package
// Shared constants, datapath operation codes and control/status structs.
// ----------------------------------------------------------------------------
package sab_pkg;

  localparam int MAX_POSITIONS_DEF = 1024;
  localparam int ALPHABET_SIZE_DEF = 256;
  localparam int CHAR_W            = 8;
  localparam int RANK_W            = 10;

  localparam logic [CHAR_W-1:0] SENTINEL_RESET = 8'd36;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SENT,
    OP_CLR,
    OP_CNT_A,
    OP_SUM,
    OP_SCAT_A,
    OP_CLS0,
    OP_SHF,
    OP_CNT_N,
    OP_SCAT_N,
    OP_RENUM,
    OP_COPY,
    OP_DBL,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] sub;
    logic       lim_alpha;
    logic       cnt_zero;
    logic       cnt_top;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       load_en;
    logic       read_en;
  } sab_cmd_t;

  typedef struct packed {
    logic last;
    logic shift_lt_n;
  } sab_stat_t;

endpackage

// ===== rtl/core/suffix_array_builder.sv =====
// ----------------------------------------------------------------------------
// Suffix array builder
// Loads a text, sorts its cyclic shifts by prefix doubling, serves ranks.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// request   start, busy            req_type, char_in, last_char, read_rank
// config    sentinel_byte_we       sentinel_byte
// result    valid (one cycle)      suffix_start, in_range, overflowed
//
// Loads and reads are taken one per cycle while busy is low; a read result
// appears in the cycle after its transaction. A load with last_char raises
// busy for the build. Reset is synchronous and clears control state;
// results cannot be stalled.
// ----------------------------------------------------------------------------
`include "suffix_array_builder_defines.svh"

module suffix_array_builder #(
  parameter int MAX_POSITIONS = sab_pkg::MAX_POSITIONS_DEF,
  parameter int ALPHABET_SIZE = sab_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type,
  input  logic [sab_pkg::CHAR_W-1:0]  char_in,
  input  logic                        last_char,
  input  logic [sab_pkg::RANK_W-1:0]  read_rank,
  input  logic                        sentinel_byte_we,
  input  logic [sab_pkg::CHAR_W-1:0]  sentinel_byte,
  output logic                        valid,
  output logic [sab_pkg::RANK_W-1:0]  suffix_start,
  output logic                        in_range,
  output logic                        overflowed
);

  sab_pkg::sab_cmd_t  cmd;
  sab_pkg::sab_stat_t stat;

  sab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req_type),
    .last_char (last_char),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  sab_datapath #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .char_in          (char_in),
    .read_rank        (read_rank),
    .sentinel_byte_we (sentinel_byte_we),
    .sentinel_byte    (sentinel_byte),
    .valid            (valid),
    .suffix_start     (suffix_start),
    .in_range         (in_range),
    .overflowed       (overflowed)
  );

  `SAB_ASSERT_NEXT(a_read_result, clk, rst, start && !busy && req_type == sab_pkg::REQ_READ, valid)
  `SAB_ASSERT_NEXT(a_build_busy, clk, rst, start && !busy && req_type == sab_pkg::REQ_LOAD && last_char, busy)
  `SAB_ASSERT_SAME(a_no_result_busy, clk, rst, busy, !valid)

endmodule

// ===== rtl/core/sab_ctrl.sv =====
// ----------------------------------------------------------------------------
// Suffix array builder controller
// Sequences the build passes and element sub-steps, and accepts transactions.
// ----------------------------------------------------------------------------
module sab_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                req_type,
  input  logic                last_char,
  input  sab_pkg::sab_stat_t  stat,
  output sab_pkg::sab_cmd_t   cmd,
  output logic                busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_SENT, S_CLR_A, S_CNT_A, S_SUM_A, S_SCAT_A, S_CLS0, S_CHK,
    S_SHF, S_CLR_N, S_CNT_N, S_SUM_N, S_SCAT_N, S_RENUM, S_COPY, S_DBL
  } state_t;

  state_t     state, state_next, nxt;
  logic [1:0] sub, sub_next, nsub;
  logic       elem, back, nxt_back;

  always_comb begin
    cmd        = '0;
    cmd.op     = sab_pkg::OP_NONE;
    cmd.sub    = sub;
    state_next = state;
    sub_next   = sub;
    nxt        = S_IDLE;
    nsub       = 2'd0;
    elem       = 1'b0;
    back       = 1'b0;
    nxt_back   = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.load_en = start && (req_type == sab_pkg::REQ_LOAD);
        cmd.read_en = start && (req_type == sab_pkg::REQ_READ);
        if (cmd.load_en && last_char) begin
          state_next = S_SENT;
        end
      end
      S_SENT: begin
        cmd.op       = sab_pkg::OP_SENT;
        cmd.cnt_zero = 1'b1;
        sub_next     = 2'd0;
        state_next   = S_CLR_A;
      end
      S_CLR_A: begin
        cmd.op = sab_pkg::OP_CLR; cmd.lim_alpha = 1'b1;
        elem = 1'b1; nsub = 2'd0; nxt = S_CNT_A;
      end
      S_CNT_A: begin
        cmd.op = sab_pkg::OP_CNT_A;
        elem = 1'b1; nsub = 2'd2; nxt = S_SUM_A;
      end
      S_SUM_A: begin
        cmd.op = sab_pkg::OP_SUM; cmd.lim_alpha = 1'b1;
        elem = 1'b1; nsub = 2'd1; nxt = S_SCAT_A;
      end
      S_SCAT_A: begin
        cmd.op = sab_pkg::OP_SCAT_A;
        elem = 1'b1; nsub = 2'd2; nxt = S_CLS0;
      end
      S_CLS0: begin
        cmd.op = sab_pkg::OP_CLS0;
        elem = 1'b1; nsub = 2'd2; nxt = S_CHK;
      end
      S_CHK: begin
        sub_next = 2'd0;
        if (stat.shift_lt_n) begin
          cmd.cnt_zero = 1'b1;
          state_next   = S_SHF;
        end else begin
          cmd.op     = sab_pkg::OP_FIN;
          state_next = S_IDLE;
        end
      end
      S_SHF: begin
        cmd.op = sab_pkg::OP_SHF;
        elem = 1'b1; nsub = 2'd1; nxt = S_CLR_N;
      end
      S_CLR_N: begin
        cmd.op = sab_pkg::OP_CLR;
        elem = 1'b1; nsub = 2'd0; nxt = S_CNT_N;
      end
      S_CNT_N: begin
        cmd.op = sab_pkg::OP_CNT_N;
        elem = 1'b1; nsub = 2'd3; nxt = S_SUM_N;
      end
      S_SUM_N: begin
        cmd.op = sab_pkg::OP_SUM;
        elem = 1'b1; nsub = 2'd1; nxt = S_SCAT_N; nxt_back = 1'b1;
      end
      S_SCAT_N: begin
        cmd.op = sab_pkg::OP_SCAT_N;
        elem = 1'b1; nsub = 2'd3; nxt = S_RENUM; back = 1'b1;
      end
      S_RENUM: begin
        cmd.op = sab_pkg::OP_RENUM;
        elem = 1'b1; nsub = 2'd2; nxt = S_COPY;
      end
      S_COPY: begin
        cmd.op = sab_pkg::OP_COPY;
        elem = 1'b1; nsub = 2'd1; nxt = S_DBL;
      end
      S_DBL: begin
        cmd.op     = sab_pkg::OP_DBL;
        state_next = S_CHK;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Common stepping for the per-element passes.
    if (elem) begin
      if (sub == nsub) begin
        sub_next = 2'd0;
        if (stat.last) begin
          state_next = nxt;
          if (nxt_back) begin
            cmd.cnt_top = 1'b1;
          end else begin
            cmd.cnt_zero = 1'b1;
          end
        end else if (back) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end else begin
        sub_next = sub + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sub   <= 2'd0;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      sub   <= sub_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// ===== rtl/core/sab_datapath.sv =====
// ----------------------------------------------------------------------------
// Suffix array builder datapath
// Text, order, class and bucket memories with the per-step arithmetic.
// ----------------------------------------------------------------------------
module sab_datapath #(
  parameter int MAX_POSITIONS = sab_pkg::MAX_POSITIONS_DEF,
  parameter int ALPHABET_SIZE = sab_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sab_pkg::sab_cmd_t           cmd,
  output sab_pkg::sab_stat_t          stat,
  input  logic [sab_pkg::CHAR_W-1:0]  char_in,
  input  logic [sab_pkg::RANK_W-1:0]  read_rank,
  input  logic                        sentinel_byte_we,
  input  logic [sab_pkg::CHAR_W-1:0]  sentinel_byte,
  output logic                        valid,
  output logic [sab_pkg::RANK_W-1:0]  suffix_start,
  output logic                        in_range,
  output logic                        overflowed
);

  localparam int CH   = sab_pkg::CHAR_W;
  localparam int PW   = $clog2(MAX_POSITIONS);
  localparam int CW   = PW + 1;
  localparam int SW   = PW + 2;
  localparam int BD   = (MAX_POSITIONS > ALPHABET_SIZE) ? MAX_POSITIONS : ALPHABET_SIZE;
  localparam int BW   = $clog2(BD);
  localparam int CMPW = (CW > sab_pkg::RANK_W) ? CW : sab_pkg::RANK_W;

  logic [CH-1:0] text_mem    [MAX_POSITIONS];
  logic [PW-1:0] order_mem   [MAX_POSITIONS];
  logic [PW-1:0] class_mem   [MAX_POSITIONS];
  logic [PW-1:0] shifted_mem [MAX_POSITIONS];
  logic [PW-1:0] newcls_mem  [MAX_POSITIONS];
  logic [CW-1:0] bucket_mem  [BD];

  logic [CH-1:0] text_rd;
  logic [PW-1:0] order_rd, class_rd0, class_rd1, shifted_rd, newcls_rd;
  logic [CW-1:0] bucket_rd;

  logic [PW-1:0] len;
  logic          ovf;
  logic          built;
  logic [CW-1:0] n;
  logic [SW-1:0] shift;
  logic [BW-1:0] i;
  logic [PW-1:0] rank;
  logic [CW-1:0] acc;
  logic [BW-1:0] bidx;
  logic [PW-1:0] r_p;
  logic [CH-1:0] prev_s;
  logic [PW-1:0] prev_c0, prev_c1;
  logic [CH-1:0] sentinel;
  logic          in_range_q, ovf_q;

  logic [PW-1:0] eff_len;
  logic          room;
  logic          text_we;
  logic [PW-1:0] text_wa;
  logic [CH-1:0] text_wd;
  logic [PW-1:0] text_ra, order_ra, class_ra0, class_ra1, idx;
  logic          bucket_we;
  logic [BW-1:0] bucket_ra, bucket_wa;
  logic [CW-1:0] bucket_wd, bm1;
  logic          order_we, class_we, shifted_we, newcls_we;
  logic [PW-1:0] order_wa, order_wd, class_wa, class_wd, shifted_wd;
  logic [PW-1:0] rank_new;
  logic          diff;
  logic [BW:0]   lim;

  function automatic logic [CH-1:0] sym(input logic [CH-1:0] b);
    return ({1'b0, b} < (CH+1)'(ALPHABET_SIZE)) ? b : CH'(ALPHABET_SIZE - 1);
  endfunction

  // Operand is known to be below twice the modulus.
  function automatic logic [PW-1:0] wrap(input logic [SW-1:0] x, input logic [CW-1:0] m);
    return (x >= SW'(m)) ? PW'(x - SW'(m)) : PW'(x);
  endfunction

  always_comb begin
    idx      = i[PW-1:0];
    eff_len  = built ? '0 : len;
    room     = eff_len < PW'(MAX_POSITIONS - 1);
    text_we  = cmd.load_en && room;
    text_wa  = eff_len;
    text_wd  = char_in;
    if (cmd.op == sab_pkg::OP_SENT) begin
      text_we = 1'b1;
      text_wa = len;
      text_wd = sentinel;
    end
    text_ra   = (cmd.op == sab_pkg::OP_CLS0) ? order_rd : idx;
    order_ra  = (cmd.op == sab_pkg::OP_NONE) ? PW'(read_rank) : idx;
    class_ra0 = (cmd.op == sab_pkg::OP_RENUM) ? order_rd : shifted_rd;
    class_ra1 = wrap(SW'(order_rd) + shift, n);

    unique case (cmd.op)
      sab_pkg::OP_CNT_A, sab_pkg::OP_SCAT_A: bucket_ra = BW'(sym(text_rd));
      sab_pkg::OP_CNT_N, sab_pkg::OP_SCAT_N: bucket_ra = BW'(class_rd0);
      default:                               bucket_ra = i;
    endcase

    bm1       = bucket_rd - CW'(1);
    bucket_we = 1'b0;
    bucket_wa = bidx;
    bucket_wd = bucket_rd + CW'(1);
    order_we  = 1'b0;
    order_wa  = bm1[PW-1:0];
    order_wd  = r_p;
    unique case (cmd.op)
      sab_pkg::OP_CLR: begin
        bucket_we = 1'b1;
        bucket_wa = i;
        bucket_wd = '0;
      end
      sab_pkg::OP_CNT_A: bucket_we = (cmd.sub == 2'd2);
      sab_pkg::OP_CNT_N: bucket_we = (cmd.sub == 2'd3);
      sab_pkg::OP_SUM: begin
        bucket_we = (cmd.sub == 2'd1);
        bucket_wa = i;
        bucket_wd = acc + bucket_rd;
      end
      sab_pkg::OP_SCAT_A: begin
        bucket_we = (cmd.sub == 2'd2);
        bucket_wd = bm1;
        order_we  = (cmd.sub == 2'd2);
        order_wd  = idx;
      end
      sab_pkg::OP_SCAT_N: begin
        bucket_we = (cmd.sub == 2'd3);
        bucket_wd = bm1;
        order_we  = (cmd.sub == 2'd3);
      end
      default: begin
      end
    endcase

    diff = (cmd.op == sab_pkg::OP_CLS0) ? (sym(text_rd) != prev_s)
                                        : ((class_rd0 != prev_c0) || (class_rd1 != prev_c1));
    rank_new = (i == '0) ? '0 : (diff ? rank + PW'(1) : rank);

    class_we = 1'b0;
    class_wa = r_p;
    class_wd = rank_new;
    if (cmd.op == sab_pkg::OP_CLS0 && cmd.sub == 2'd2) begin
      class_we = 1'b1;
    end else if (cmd.op == sab_pkg::OP_COPY && cmd.sub == 2'd1) begin
      class_we = 1'b1;
      class_wa = idx;
      class_wd = newcls_rd;
    end
    shifted_we = (cmd.op == sab_pkg::OP_SHF) && (cmd.sub == 2'd1);
    shifted_wd = wrap(SW'(order_rd) + SW'(n) - shift, n);
    newcls_we  = (cmd.op == sab_pkg::OP_RENUM) && (cmd.sub == 2'd2);

    lim = cmd.lim_alpha ? (BW+1)'(ALPHABET_SIZE) : (BW+1)'(n);
    stat.last       = (cmd.op == sab_pkg::OP_SCAT_N) ? (i == '0)
                                                     : ({1'b0, i} == lim - (BW+1)'(1));
    stat.shift_lt_n = shift < SW'(n);
  end

  // Memories: one write port each, registered reads.
  always_ff @(posedge clk) begin
    if (text_we)    text_mem[text_wa]     <= text_wd;
    if (order_we)   order_mem[order_wa]   <= order_wd;
    if (class_we)   class_mem[class_wa]   <= class_wd;
    if (shifted_we) shifted_mem[idx]      <= shifted_wd;
    if (newcls_we)  newcls_mem[r_p]       <= rank_new;
    if (bucket_we)  bucket_mem[bucket_wa] <= bucket_wd;
    text_rd    <= text_mem[text_ra];
    order_rd   <= order_mem[order_ra];
    class_rd0  <= class_mem[class_ra0];
    class_rd1  <= class_mem[class_ra1];
    shifted_rd <= shifted_mem[idx];
    newcls_rd  <= newcls_mem[idx];
    bucket_rd  <= bucket_mem[bucket_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      ovf      <= 1'b0;
      built    <= 1'b0;
      valid    <= 1'b0;
      sentinel <= sab_pkg::SENTINEL_RESET;
    end else begin
      valid <= cmd.read_en;
      if (sentinel_byte_we) begin
        sentinel <= sentinel_byte;
      end
      if (cmd.load_en) begin
        built <= 1'b0;
        if (room) begin
          len <= eff_len + PW'(1);
          if (built) begin
            ovf <= 1'b0;
          end
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.op == sab_pkg::OP_FIN) begin
        built <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    in_range_q <= built && (CMPW'(read_rank) < CMPW'(n));
    ovf_q      <= ovf;
    if (cmd.op == sab_pkg::OP_SENT) begin
      n     <= CW'(len) + CW'(1);
      shift <= SW'(1);
    end
    if (cmd.op == sab_pkg::OP_DBL) begin
      shift <= shift << 1;
    end
    if (cmd.cnt_zero) begin
      i <= '0;
    end else if (cmd.cnt_top) begin
      i <= BW'(n - CW'(1));
    end else if (cmd.cnt_inc) begin
      i <= i + BW'(1);
    end else if (cmd.cnt_dec) begin
      i <= i - BW'(1);
    end
    if (cmd.op == sab_pkg::OP_CLR) begin
      acc <= '0;
    end
    if (cmd.op == sab_pkg::OP_SUM && cmd.sub == 2'd1) begin
      acc <= bucket_wd;
    end
    if (((cmd.op == sab_pkg::OP_CNT_A || cmd.op == sab_pkg::OP_SCAT_A) && cmd.sub == 2'd1) ||
        ((cmd.op == sab_pkg::OP_CNT_N || cmd.op == sab_pkg::OP_SCAT_N) && cmd.sub == 2'd2)) begin
      bidx <= bucket_ra;
    end
    if (cmd.sub == 2'd1) begin
      if (cmd.op == sab_pkg::OP_CLS0 || cmd.op == sab_pkg::OP_RENUM) begin
        r_p <= order_rd;
      end else if (cmd.op == sab_pkg::OP_SCAT_N) begin
        r_p <= shifted_rd;
      end
    end
    if (cmd.sub == 2'd2) begin
      if (cmd.op == sab_pkg::OP_CLS0) begin
        rank   <= rank_new;
        prev_s <= sym(text_rd);
      end else if (cmd.op == sab_pkg::OP_RENUM) begin
        rank    <= rank_new;
        prev_c0 <= class_rd0;
        prev_c1 <= class_rd1;
      end
    end
  end

  assign suffix_start = in_range_q ? sab_pkg::RANK_W'(order_rd) : '0;
  assign in_range     = in_range_q;
  assign overflowed   = ovf_q;

endmodule

// ===== verif/suffix_array_checker.sv =====
// ----------------------------------------------------------------------------
// Suffix array builder checker
// Watches the request, config and result channels, predicts every read
// result from its own suffix sort, and compares results in order.
// ----------------------------------------------------------------------------
module suffix_array_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        req_type,
  input  logic [sab_pkg::CHAR_W-1:0]  char_in,
  input  logic                        last_char,
  input  logic [sab_pkg::RANK_W-1:0]  read_rank,
  input  logic                        sentinel_byte_we,
  input  logic [sab_pkg::CHAR_W-1:0]  sentinel_byte,
  input  logic                        valid,
  input  logic [sab_pkg::RANK_W-1:0]  suffix_start,
  input  logic                        in_range,
  input  logic                        overflowed,
  output int                          errors,
  output int                          pending,
  output int                          reads_checked,
  output int                          texts_built
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPOS = sab_pkg::MAX_POSITIONS_DEF;
  localparam int NSYM = sab_pkg::ALPHABET_SIZE_DEF;

  typedef struct packed {
    logic [sab_pkg::RANK_W-1:0] pos;
    logic                       hit;
    logic                       ovf;
  } rank_answer_t;

  rank_answer_t answers_due[$];

  logic [sab_pkg::CHAR_W-1:0] text_bytes [NPOS];
  int unsigned shift_order [NPOS];
  int unsigned shift_class [NPOS];
  int unsigned rotated [NPOS];
  int unsigned next_class [NPOS];
  int unsigned tally [NPOS];
  int unsigned text_len;
  int unsigned sorted_len;
  logic        text_cut;
  logic        sorted_ok;
  logic [sab_pkg::CHAR_W-1:0] sentinel_val;

  function automatic int unsigned sym(logic [sab_pkg::CHAR_W-1:0] b);
    return (b < NSYM) ? int'(b) : NSYM - 1;
  endfunction

  // Counting sort on bytes, then prefix doubling over the cyclic shifts.
  function automatic void sort_shifts();
    int unsigned n, cls, span, p, c, a, b;
    text_bytes[text_len] = sentinel_val;
    n = text_len + 1;
    for (int i = 0; i < NSYM; i++) tally[i] = 0;
    for (int i = 0; i < n; i++) tally[sym(text_bytes[i])]++;
    for (int i = 1; i < NSYM; i++) tally[i] += tally[i-1];
    for (int i = 0; i < n; i++) begin
      c = sym(text_bytes[i]);
      tally[c]--;
      shift_order[tally[c]] = i;
    end
    cls = 0;
    shift_class[shift_order[0]] = 0;
    for (int i = 1; i < n; i++) begin
      if (sym(text_bytes[shift_order[i]]) != sym(text_bytes[shift_order[i-1]])) cls++;
      shift_class[shift_order[i]] = cls;
    end
    for (span = 1; span < n; span = span << 1) begin
      for (int i = 0; i < n; i++) rotated[i] = (shift_order[i] + n - span) % n;
      for (int i = 0; i < n; i++) tally[i] = 0;
      for (int i = 0; i < n; i++) tally[shift_class[rotated[i]]]++;
      for (int i = 1; i < n; i++) tally[i] += tally[i-1];
      for (int i = n; i > 0; i--) begin
        p = rotated[i-1];
        c = shift_class[p];
        tally[c]--;
        shift_order[tally[c]] = p;
      end
      cls = 0;
      next_class[shift_order[0]] = 0;
      for (int i = 1; i < n; i++) begin
        a = shift_order[i];
        b = shift_order[i-1];
        if (shift_class[a] != shift_class[b] ||
            shift_class[(a + span) % n] != shift_class[(b + span) % n]) cls++;
        next_class[a] = cls;
      end
      for (int i = 0; i < n; i++) shift_class[i] = next_class[i];
    end
    sorted_len = n;
    sorted_ok = 1'b1;
  endfunction

  task automatic report(string what, int want, int got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    rank_answer_t want;
    if (rst) begin
      answers_due.delete();
      text_len = 0;
      sorted_len = 0;
      text_cut = 1'b0;
      sorted_ok = 1'b0;
      sentinel_val = sab_pkg::SENTINEL_RESET;
      errors = 0;
      reads_checked = 0;
      texts_built = 0;
    end else begin
      if (valid) begin
        if (answers_due.size() == 0) begin
          report("outstanding reads", 1, 0);
        end else begin
          want = answers_due.pop_front();
          reads_checked++;
          if (suffix_start !== want.pos) report("suffix_start", want.pos, suffix_start);
          if (in_range !== want.hit) report("in_range", want.hit, in_range);
          if (overflowed !== want.ovf) report("overflowed", want.ovf, overflowed);
        end
      end
      if (sentinel_byte_we) sentinel_val = sentinel_byte;
      if (start && !busy) begin
        if (req_type == sab_pkg::REQ_LOAD) begin
          // The first byte after a finished build begins a fresh text.
          if (sorted_ok) begin
            sorted_ok = 1'b0;
            sorted_len = 0;
            text_len = 0;
            text_cut = 1'b0;
          end
          if (text_len < NPOS - 1) begin
            text_bytes[text_len] = char_in;
            text_len++;
          end else begin
            text_cut = 1'b1;
          end
          if (last_char) begin
            sort_shifts();
            texts_built++;
          end
        end else begin
          if (sorted_ok && read_rank < sorted_len) begin
            want.pos = sab_pkg::RANK_W'(shift_order[read_rank]);
            want.hit = 1'b1;
          end else begin
            want.pos = '0;
            want.hit = 1'b0;
          end
          want.ovf = text_cut;
          answers_due.push_back(want);
        end
      end
    end
    pending = answers_due.size();
  end

endmodule

// ===== verif/suffix_array_builder_tb.sv =====
// ----------------------------------------------------------------------------
// Suffix array builder testbench
// Streams texts into the builder, reads back ranks with random gaps and
// sentinel settings, and leaves result checking to the checker module.
// ----------------------------------------------------------------------------
module suffix_array_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int ITEM_GOAL   = 1850;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic req_type = sab_pkg::REQ_LOAD;
  logic [sab_pkg::CHAR_W-1:0] char_in = '0;
  logic last_char = 1'b0;
  logic [sab_pkg::RANK_W-1:0] read_rank = '0;
  logic sentinel_byte_we = 1'b0;
  logic [sab_pkg::CHAR_W-1:0] sentinel_byte = '0;
  logic valid;
  logic [sab_pkg::RANK_W-1:0] suffix_start;
  logic in_range;
  logic overflowed;

  int errors, pending, reads_checked, texts_built;
  int items = 0;
  int cycles = 0;
  bit no_gaps = 1'b0;

  always #6 clk = ~clk;

  suffix_array_builder uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .char_in(char_in), .last_char(last_char),
    .read_rank(read_rank), .sentinel_byte_we(sentinel_byte_we),
    .sentinel_byte(sentinel_byte), .valid(valid), .suffix_start(suffix_start),
    .in_range(in_range), .overflowed(overflowed)
  );

  suffix_array_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .char_in(char_in), .last_char(last_char),
    .read_rank(read_rank), .sentinel_byte_we(sentinel_byte_we),
    .sentinel_byte(sentinel_byte), .valid(valid), .suffix_start(suffix_start),
    .in_range(in_range), .overflowed(overflowed), .errors(errors),
    .pending(pending), .reads_checked(reads_checked), .texts_built(texts_built)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Holds one transaction on the request ports until it is taken, then may idle for a random gap.
  task automatic issue(logic kind, logic [7:0] ch, logic fin, logic [9:0] rank);
    int roll, gap;
    start <= 1'b1;
    req_type <= kind;
    char_in <= ch;
    last_char <= fin;
    read_rank <= rank;
    do @(posedge clk); while (busy);
    items++;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load(logic [7:0] ch, logic fin);
    issue(sab_pkg::REQ_LOAD, ch, fin, 10'($urandom));
  endtask

  task automatic read(logic [9:0] rank);
    issue(sab_pkg::REQ_READ, 8'($urandom), 1'($urandom), rank);
  endtask

  task automatic set_sentinel(logic [7:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    sentinel_byte_we <= 1'b1;
    sentinel_byte <= value;
    @(posedge clk);
    sentinel_byte_we <= 1'b0;
    sentinel_byte <= 8'($urandom);
    @(posedge clk);
  endtask

  // One text with random bytes, with occasional reads while loading, followed by a burst of rank reads.
  task automatic text_and_reads(int len);
    int n, roll;
    for (int i = 0; i < len; i++) begin
      // Occasionally read in the middle of loading; no array is valid after the first byte.
      if ($urandom_range(0, 19) == 0) read(10'($urandom));
      load(8'($urandom), i == len - 1);
    end
    n = (len < 1023 ? len : 1023) + 1;
    repeat ($urandom_range(3, 12)) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) read(10'($urandom_range(0, n - 1)));
      else if (roll < 88) read(10'(n < 1024 ? n : 1023));
      else read(10'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: read before any build, a classic word, byte extremes,
    // and a read after a new text voids the finished array.
    read(10'd0);
    load("b", 0); load("a", 0); load("n", 0);
    load("a", 0); load("n", 0); load("a", 1);
    for (int r = 0; r <= 7; r++) read(10'(r));
    read(10'd1023);
    load(8'd0, 0); load(8'd255, 1);
    read(10'd0); read(10'd1); read(10'd2);
    load("x", 0);
    read(10'd0);
    load("y", 1);
    read(10'd1);

    set_sentinel(8'd0);
    // Periodic text; the sentinel keeps its cyclic shifts distinct.
    for (int i = 0; i < 6; i++) load(i % 2 ? "b" : "a", i == 5);
    for (int r = 0; r < 7; r++) read(10'(r));

    set_sentinel(8'd255);
    text_and_reads(9);
    set_sentinel(sab_pkg::SENTINEL_RESET);

    // Over capacity: two bytes dropped, the dropped last byte still builds.
    no_gaps = 1'b1;
    text_and_reads(1025);
    read(10'd1023);
    no_gaps = 1'b0;

    while (items < ITEM_GOAL) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: set_sentinel(8'd0);
          1: set_sentinel(8'd255);
          default: set_sentinel(8'($urandom));
        endcase
      end
      text_and_reads($urandom_range(0, 9) == 0 ? $urandom_range(25, 120)
                                               : $urandom_range(1, 24));
    end
    no_gaps = 1'b0;

    start <= 1'b0;
    while (pending != 0 || busy) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d transactions: %0d texts built, %0d rank reads checked.",
             items, texts_built, reads_checked);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
